/* hdl/rwmf_pkg.sv */
package rwmf_pkg;

   localparam int PIX_W = 8;
   localparam int RAD_W = 2;
   localparam int WID_W = 11;
   localparam int HGT_W = 13;
   localparam int ROW_W = 12;
   localparam int SLOT_FIELD_W = 4;
   localparam int SPAN_W = 3;
   localparam int BIT_W = 3;
   localparam int LIN_W = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 13;
   localparam int WORD_W = 4 * PIX_W;
   localparam int CHANNELS = 3;

   localparam logic [WID_W-1:0] RESET_WIDTH = 11'd1024;
   localparam logic [HGT_W-1:0] RESET_HEIGHT = 13'd1024;
   localparam logic [HGT_W-1:0] HEIGHT_LIMIT = 13'd4096;
   localparam logic [RAD_W-1:0] RESET_RADIUS = 2'd1;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_GATHER,
      BK_FLUSH,
      BK_PREP,
      BK_SELECT,
      BK_OUTPUT
   } back_state_type;

   typedef struct packed {
      logic [RAD_W-1:0] radius;
      logic [WID_W-1:0] width;
      logic [HGT_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic [ROW_W-1:0]        row;
      logic [WID_W-1:0]        col;
      logic [SLOT_FIELD_W-1:0] slot;
      logic                    last;
   } job_type;

   typedef struct packed {
      logic                    en;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [WID_W-1:0]        col;
      logic [WORD_W-1:0]       data;
   } store_wr_type;

endpackage

/* hdl/rwmf_if.sv */
interface rwmf_req_if;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [rwmf_pkg::PIX_W-1:0] in_red;
   logic [rwmf_pkg::PIX_W-1:0] in_green;
   logic [rwmf_pkg::PIX_W-1:0] in_blue;
   logic [rwmf_pkg::PIX_W-1:0] in_alpha;
   modport source (output valid, kind, in_red, in_green, in_blue, in_alpha, input ready);
   modport sink (input valid, kind, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface rwmf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rwmf_pkg::PIX_W-1:0] out_red;
   logic [rwmf_pkg::PIX_W-1:0] out_green;
   logic [rwmf_pkg::PIX_W-1:0] out_blue;
   logic [rwmf_pkg::PIX_W-1:0] out_alpha;
   logic                       frame_end;
   modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_end,
                   input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, frame_end,
                 output ready);
endinterface

interface rwmf_csr_if;
   logic                            valid;
   logic                            ready;
   logic [rwmf_pkg::CSR_IDX_W-1:0]  index;
   logic [rwmf_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hdl/rgba_window_median_filter.sv */
// Median filter over a square window on one RGBA frame taken in raster order. An output
// pixel is produced once its window is complete, about radius rows plus radius pixels after
// the matching input; drain transactions release the outputs left at the end of the frame.
// Each output walks its (2r+1)x(2r+1) window through the line store, one read per cycle
// with positions outside the frame skipped, then picks the median of all three colors in
// eight bit-plane steps. After a transaction that releases an output, the input side holds
// off new transactions until that output's window has been read, so a result waiting at
// the output stalls the input once one more output has been released.
module rgba_window_median_filter #(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH = 1024
) (
   input logic         clock,
   input logic         reset,
   rwmf_req_if.sink    req_chan,
   rwmf_rsp_if.source  rsp_chan,
   rwmf_csr_if.sink    csr_chan
);
   rwmf_pkg::cfg_type      cfg;
   rwmf_pkg::store_wr_type store_wr;
   rwmf_pkg::job_type      job, job_head;
   logic job_push, job_pop, queue_full, queue_empty, gather_done;

   rwmf_front #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan), .csr_chan(csr_chan),
      .queue_full(queue_full), .gather_done(gather_done), .cfg(cfg),
      .store_wr(store_wr), .job_push(job_push), .job(job)
   );

   rwmf_job_queue u_queue (
      .clock(clock), .reset(reset), .push(job_push), .job_in(job), .pop(job_pop),
      .full(queue_full), .empty(queue_empty), .head(job_head)
   );

   rwmf_back #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .store_wr(store_wr),
      .queue_empty(queue_empty), .job_head(job_head), .queue_pop(job_pop),
      .gather_done(gather_done), .rsp_chan(rsp_chan)
   );

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !queue_full) else $error("job pushed into a full queue");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !queue_empty) else $error("job popped from an empty queue");

   a_one_window: assert property (@(posedge clock) disable iff (reset)
      job_push |=> !job_push) else $error("second job pushed before window was read");

   a_no_write_in_gather: assert property (@(posedge clock) disable iff (reset)
      gather_done |-> !store_wr.en) else $error("line store written during window read");

endmodule

/* hdl/rwmf_front.sv */
module rwmf_front #(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   rwmf_req_if.sink               req_chan,
   rwmf_csr_if.sink               csr_chan,
   input  logic                   queue_full,
   input  logic                   gather_done,
   output rwmf_pkg::cfg_type      cfg,
   output rwmf_pkg::store_wr_type store_wr,
   output logic                   job_push,
   output rwmf_pkg::job_type      job
);
   localparam int SLOTS = 2 * MAX_RADIUS + 2;
   localparam logic [rwmf_pkg::SLOT_FIELD_W-1:0] LAST_SLOT =
      rwmf_pkg::SLOT_FIELD_W'(SLOTS - 1);
   localparam logic [rwmf_pkg::WID_W-1:0] WMAX =
      rwmf_pkg::WID_W'((MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH);
   localparam logic [rwmf_pkg::RAD_W-1:0] RMAX =
      rwmf_pkg::RAD_W'((MAX_RADIUS > 3) ? 3 : MAX_RADIUS);

   logic [rwmf_pkg::RAD_W-1:0] radius_ff, radius_in;
   logic [rwmf_pkg::WID_W-1:0] width_ff, width_in;
   logic [rwmf_pkg::HGT_W-1:0] height_ff, height_in;
   logic [rwmf_pkg::WID_W-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [rwmf_pkg::ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [rwmf_pkg::SLOT_FIELD_W-1:0] in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic [rwmf_pkg::LIN_W-1:0] in_lin_ff, in_lin_in, out_lin_ff, out_lin_in;
   logic done_ff, done_in;
   logic pending_ff, pending_in;
   logic accept, take, emit, last, restart;
   logic [rwmf_pkg::HGT_W-1:0] rw_prod;
   logic [rwmf_pkg::LIN_W-1:0] lag;
   logic [rwmf_pkg::WID_W-1:0] wval;
   logic [rwmf_pkg::HGT_W-1:0] hval;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !pending_ff && !queue_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign take = accept && (req_chan.kind == rwmf_pkg::KIND_PIXEL) && !done_ff;

   assign rw_prod = rwmf_pkg::HGT_W'(radius_ff) * rwmf_pkg::HGT_W'(width_ff);
   assign lag = rwmf_pkg::LIN_W'(rw_prod) + rwmf_pkg::LIN_W'(radius_ff);
   assign last = ({1'b0, out_row_ff} == height_ff - 13'd1) && (out_col_ff == width_ff - 11'd1);

   always_comb begin
      radius_in = radius_ff;
      width_in = width_ff;
      height_in = height_ff;
      restart = 1'b0;
      wval = csr_chan.data[rwmf_pkg::WID_W-1:0];
      hval = csr_chan.data[rwmf_pkg::HGT_W-1:0];
      if (csr_chan.valid) begin
         case (rwmf_pkg::csr_index_type'(csr_chan.index))
            rwmf_pkg::CSR_RADIUS: begin
               radius_in = (csr_chan.data[rwmf_pkg::RAD_W-1:0] > RMAX) ? RMAX :
                           csr_chan.data[rwmf_pkg::RAD_W-1:0];
               restart = 1'b1;
            end
            rwmf_pkg::CSR_WIDTH: begin
               width_in = (wval == 11'd0) ? 11'd1 : ((wval > WMAX) ? WMAX : wval);
               restart = 1'b1;
            end
            rwmf_pkg::CSR_HEIGHT: begin
               height_in = (hval == 13'd0) ? 13'd1 :
                           ((hval > rwmf_pkg::HEIGHT_LIMIT) ? rwmf_pkg::HEIGHT_LIMIT : hval);
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      in_slot_in = in_slot_ff;
      in_lin_in = in_lin_ff;
      done_in = done_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      out_slot_in = out_slot_ff;
      out_lin_in = out_lin_ff;
      if (take) begin
         in_col_in = in_col_ff + 11'd1;
         in_lin_in = in_lin_ff + 24'd1;
         if (in_col_ff + 11'd1 >= width_ff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 12'd1;
            in_slot_in = (in_slot_ff == LAST_SLOT) ? '0 : in_slot_ff + 4'd1;
            if ({1'b0, in_row_ff} + 13'd1 >= height_ff) begin
               in_row_in = '0;
               in_slot_in = '0;
               done_in = 1'b1;
            end
         end
      end
      emit = accept && (done_in || (in_lin_in > out_lin_ff + lag));
      if (emit) begin
         if (last) begin
            in_col_in = '0;
            in_row_in = '0;
            in_slot_in = '0;
            in_lin_in = '0;
            done_in = 1'b0;
            out_col_in = '0;
            out_row_in = '0;
            out_slot_in = '0;
            out_lin_in = '0;
         end else begin
            out_col_in = out_col_ff + 11'd1;
            out_lin_in = out_lin_ff + 24'd1;
            if (out_col_ff + 11'd1 >= width_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 12'd1;
               out_slot_in = (out_slot_ff == LAST_SLOT) ? '0 : out_slot_ff + 4'd1;
            end
         end
      end
      if (restart) begin
         in_col_in = '0;
         in_row_in = '0;
         in_slot_in = '0;
         in_lin_in = '0;
         done_in = 1'b0;
         out_col_in = '0;
         out_row_in = '0;
         out_slot_in = '0;
         out_lin_in = '0;
      end
      pending_in = pending_ff;
      if (gather_done) begin
         pending_in = 1'b0;
      end
      if (emit) begin
         pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= ((rwmf_pkg::RESET_RADIUS > RMAX) ? RMAX : rwmf_pkg::RESET_RADIUS);
         width_ff <= ((rwmf_pkg::RESET_WIDTH > WMAX) ? WMAX : rwmf_pkg::RESET_WIDTH);
         height_ff <= rwmf_pkg::RESET_HEIGHT;
         in_col_ff <= '0;
         in_row_ff <= '0;
         in_slot_ff <= '0;
         in_lin_ff <= '0;
         done_ff <= 1'b0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_slot_ff <= '0;
         out_lin_ff <= '0;
         pending_ff <= 1'b0;
      end else begin
         radius_ff <= radius_in;
         width_ff <= width_in;
         height_ff <= height_in;
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         in_slot_ff <= in_slot_in;
         in_lin_ff <= in_lin_in;
         done_ff <= done_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         out_slot_ff <= out_slot_in;
         out_lin_ff <= out_lin_in;
         pending_ff <= pending_in;
      end
   end

   assign cfg.radius = radius_ff;
   assign cfg.width = width_ff;
   assign cfg.height = height_ff;

   assign store_wr.en = take;
   assign store_wr.slot = in_slot_ff;
   assign store_wr.col = in_col_ff;
   assign store_wr.data = {req_chan.in_alpha, req_chan.in_blue, req_chan.in_green,
                           req_chan.in_red};

   assign job_push = emit;
   assign job.row = out_row_ff;
   assign job.col = out_col_ff;
   assign job.slot = out_slot_ff;
   assign job.last = last;

endmodule

/* hdl/rwmf_job_queue.sv */
module rwmf_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rwmf_pkg::job_type job_in,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output rwmf_pkg::job_type head
);
   rwmf_pkg::job_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

/* hdl/rwmf_back.sv */
module rwmf_back #(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rwmf_pkg::cfg_type      cfg,
   input  rwmf_pkg::store_wr_type store_wr,
   input  logic                   queue_empty,
   input  rwmf_pkg::job_type      job_head,
   output logic                   queue_pop,
   output logic                   gather_done,
   rwmf_rsp_if.source             rsp_chan
);
   localparam int SLOTS = 2 * MAX_RADIUS + 2;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int COL_RAW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int COL_W = (COL_RAW > rwmf_pkg::WID_W) ? rwmf_pkg::WID_W : COL_RAW;
   localparam int ADDR_W = SLOT_W + COL_W;
   localparam int DEPTH = SLOTS * (2 ** COL_W);
   localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int CNT_W = $clog2(WIN_MAX + 1);
   localparam int IDX_W = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
   localparam int PW = rwmf_pkg::PIX_W;
   localparam int NCH = rwmf_pkg::CHANNELS;

   logic [rwmf_pkg::WORD_W-1:0] mem [DEPTH];

   rwmf_pkg::back_state_type state_ff, state_in;
   rwmf_pkg::job_type job_ff;
   logic [rwmf_pkg::SPAN_W-1:0] dy_ff, dx_ff, span;
   logic rdv_ff, rdv_in, centre_ff;
   logic [rwmf_pkg::WORD_W-1:0] rd_data_ff;
   logic [CNT_W-1:0] n_ff;
   logic [NCH-1:0][PW-1:0] win_ff [WIN_MAX];
   logic [PW-1:0] alpha_ff;
   logic [WIN_MAX-1:0] cand_ff [NCH];
   logic [CNT_W-1:0] k_ff [NCH];
   logic [PW-1:0] res_ff [NCH];
   logic [rwmf_pkg::BIT_W-1:0] bit_ff;
   logic rsp_valid_ff;
   logic [PW-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff, rsp_alpha_ff;
   logic rsp_end_ff;

   logic last_pos, in_frame, load_out;
   logic [rwmf_pkg::HGT_W-1:0] row_sum, row_idx;
   logic [rwmf_pkg::ROW_W-1:0] col_sum, col_idx;
   logic [5:0] slot_sum, slot_one, slot_two;
   logic [ADDR_W-1:0] rd_addr;
   logic [WIN_MAX-1:0] zeros [NCH];
   logic [WIN_MAX-1:0] ones [NCH];
   logic [CNT_W-1:0] cnt0 [NCH];
   logic pick1 [NCH];

   assign span = {cfg.radius, 1'b0};
   assign last_pos = (dy_ff == span) && (dx_ff == span);
   assign load_out = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      row_sum = {1'b0, job_ff.row} + rwmf_pkg::HGT_W'(dy_ff);
      row_idx = row_sum - rwmf_pkg::HGT_W'(cfg.radius);
      col_sum = {1'b0, job_ff.col} + rwmf_pkg::ROW_W'(dx_ff);
      col_idx = col_sum - rwmf_pkg::ROW_W'(cfg.radius);
      in_frame = (row_sum >= rwmf_pkg::HGT_W'(cfg.radius)) && (row_idx < cfg.height)
              && (col_sum >= rwmf_pkg::ROW_W'(cfg.radius))
              && (col_idx < {1'b0, cfg.width});
      slot_sum = 6'(job_ff.slot) + 6'(dy_ff) + 6'(SLOTS) - 6'(cfg.radius);
      slot_one = (slot_sum >= 6'(SLOTS)) ? slot_sum - 6'(SLOTS) : slot_sum;
      slot_two = (slot_one >= 6'(SLOTS)) ? slot_one - 6'(SLOTS) : slot_one;
      rd_addr = {slot_two[SLOT_W-1:0], col_idx[COL_W-1:0]};
   end

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         for (int i = 0; i < WIN_MAX; i++) begin
            zeros[c][i] = cand_ff[c][i] & ~win_ff[i][c][bit_ff];
            ones[c][i] = cand_ff[c][i] & win_ff[i][c][bit_ff];
         end
         cnt0[c] = CNT_W'($countones(zeros[c]));
         pick1[c] = (k_ff[c] >= cnt0[c]);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rwmf_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               state_in = rwmf_pkg::BK_GATHER;
            end
         end
         rwmf_pkg::BK_GATHER: begin
            if (last_pos) begin
               state_in = rwmf_pkg::BK_FLUSH;
            end
         end
         rwmf_pkg::BK_FLUSH: begin
            state_in = rwmf_pkg::BK_PREP;
         end
         rwmf_pkg::BK_PREP: begin
            state_in = rwmf_pkg::BK_SELECT;
         end
         rwmf_pkg::BK_SELECT: begin
            if (bit_ff == '0) begin
               state_in = rwmf_pkg::BK_OUTPUT;
            end
         end
         rwmf_pkg::BK_OUTPUT: begin
            if (load_out) begin
               state_in = rwmf_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = rwmf_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      queue_pop = (state_ff == rwmf_pkg::BK_IDLE) && !queue_empty;
      gather_done = (state_ff == rwmf_pkg::BK_GATHER) && last_pos;
      rdv_in = (state_ff == rwmf_pkg::BK_GATHER) && in_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rwmf_pkg::BK_IDLE;
         rdv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff <= rdv_in;
         if ((state_ff == rwmf_pkg::BK_OUTPUT) && load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         mem[{store_wr.slot[SLOT_W-1:0], store_wr.col[COL_W-1:0]}] <= store_wr.data;
      end
      if (rdv_in) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      centre_ff <= (dy_ff == rwmf_pkg::SPAN_W'(cfg.radius))
                && (dx_ff == rwmf_pkg::SPAN_W'(cfg.radius));
      if (rdv_ff) begin
         win_ff[n_ff[IDX_W-1:0]] <= {rd_data_ff[23:16], rd_data_ff[15:8], rd_data_ff[7:0]};
         n_ff <= n_ff + 1'b1;
         if (centre_ff) begin
            alpha_ff <= rd_data_ff[31:24];
         end
      end
      case (state_ff)
         rwmf_pkg::BK_IDLE: begin
            job_ff <= job_head;
            dy_ff <= '0;
            dx_ff <= '0;
            n_ff <= '0;
         end
         rwmf_pkg::BK_GATHER: begin
            if (dx_ff == span) begin
               dx_ff <= '0;
               dy_ff <= dy_ff + 1'b1;
            end else begin
               dx_ff <= dx_ff + 1'b1;
            end
         end
         rwmf_pkg::BK_PREP: begin
            bit_ff <= rwmf_pkg::BIT_W'(PW - 1);
            for (int c = 0; c < NCH; c++) begin
               k_ff[c] <= n_ff >> 1;
               for (int i = 0; i < WIN_MAX; i++) begin
                  cand_ff[c][i] <= (CNT_W'(i) < n_ff);
               end
            end
         end
         rwmf_pkg::BK_SELECT: begin
            bit_ff <= bit_ff - 1'b1;
            for (int c = 0; c < NCH; c++) begin
               res_ff[c][bit_ff] <= pick1[c];
               if (pick1[c]) begin
                  k_ff[c] <= k_ff[c] - cnt0[c];
                  cand_ff[c] <= ones[c];
               end else begin
                  cand_ff[c] <= zeros[c];
               end
            end
         end
         rwmf_pkg::BK_OUTPUT: begin
            if (load_out) begin
               rsp_red_ff <= res_ff[0];
               rsp_green_ff <= res_ff[1];
               rsp_blue_ff <= res_ff[2];
               rsp_alpha_ff <= alpha_ff;
               rsp_end_ff <= job_ff.last;
            end
         end
         default: begin
            bit_ff <= bit_ff;
         end
      endcase
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_red = rsp_red_ff;
   assign rsp_chan.out_green = rsp_green_ff;
   assign rsp_chan.out_blue = rsp_blue_ff;
   assign rsp_chan.out_alpha = rsp_alpha_ff;
   assign rsp_chan.frame_end = rsp_end_ff;

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

   localparam int SLOTS = 8;
   localparam int LINE = 1024;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 150;

   typedef struct {
      logic       kind;
      logic [7:0] red, green, blue, alpha;
   } pixel_in_type;

   typedef struct {
      logic [7:0] red, green, blue, alpha;
      logic       frame_end;
   } pixel_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rwmf_req_if req();
   rwmf_rsp_if rsp();
   rwmf_csr_if csr();

   rgba_window_median_filter dut (
      .clock(clock), .reset(reset),
      .req_chan(req), .rsp_chan(rsp), .csr_chan(csr)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pixel_in_type  pending_pixels[$];
   pixel_out_type expected_pixels[$];
   int         errors = 0;
   int         cycles = 0;
   int         idle_mode = 0;
   bit         hold_req = 1'b0;
   bit         hold_done = 1'b0;
   int         hold_left = 0;
   bit         req_fire, rsp_fire;

   // Shadow copy of the filter state.
   logic [31:0] line_mem[0:SLOTS*LINE-1];
   int  radius_cfg, width_cfg, height_cfg;
   int  in_col, in_row, out_col, out_row;
   bit  frame_in_done, frame_closed;

   function automatic logic [7:0] middle_of(logic [7:0] v[49], int n);
      logic [7:0] key;
      int j;
      for (int i = 1; i < n; i++) begin
         key = v[i];
         j = i;
         while (j > 0 && v[j-1] > key) begin
            v[j] = v[j-1];
            j--;
         end
         v[j] = key;
      end
      return (n > 0) ? v[n/2] : 8'd0;
   endfunction

   function automatic void restart_frame();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frame_in_done = 1'b0;
   endfunction

   function automatic void predict_pixel(pixel_in_type p);
      logic [7:0] rv[49], gv[49], bv[49];
      logic [31:0] word;
      pixel_out_type o;
      int n, ry, cx;
      bit complete;
      n = 0;
      frame_closed = 1'b0;
      if (p.kind == rwmf_pkg::KIND_PIXEL && !frame_in_done) begin
         line_mem[(in_row % SLOTS) * LINE + in_col] = {p.alpha, p.blue, p.green, p.red};
         in_col++;
         if (in_col >= width_cfg) begin
            in_col = 0;
            in_row++;
            if (in_row >= height_cfg) begin
               in_row = 0;
               frame_in_done = 1'b1;
            end
         end
      end
      complete = frame_in_done || (in_row * width_cfg + in_col >
         out_row * width_cfg + out_col + radius_cfg * width_cfg + radius_cfg);
      if (!complete) return;
      for (int dy = -radius_cfg; dy <= radius_cfg; dy++) begin
         ry = out_row + dy;
         if (ry >= 0 && ry < height_cfg) begin
            for (int dx = -radius_cfg; dx <= radius_cfg; dx++) begin
               cx = out_col + dx;
               if (cx >= 0 && cx < width_cfg) begin
                  word = line_mem[(ry % SLOTS) * LINE + cx];
                  rv[n] = word[7:0];
                  gv[n] = word[15:8];
                  bv[n] = word[23:16];
                  n++;
               end
            end
         end
      end
      word = line_mem[(out_row % SLOTS) * LINE + out_col];
      o.red = middle_of(rv, n);
      o.green = middle_of(gv, n);
      o.blue = middle_of(bv, n);
      o.alpha = word[31:24];
      o.frame_end = (out_row == height_cfg - 1) && (out_col == width_cfg - 1);
      expected_pixels.push_back(o);
      if (o.frame_end) begin
         restart_frame();
         frame_closed = 1'b1;
      end else begin
         out_col++;
         if (out_col >= width_cfg) begin
            out_col = 0;
            out_row++;
         end
      end
   endfunction

   task automatic send(logic kind, logic [31:0] rgba);
      pixel_in_type p;
      p.kind = kind;
      {p.alpha, p.blue, p.green, p.red} = rgba;
      predict_pixel(p);
      pending_pixels.push_back(p);
   endtask

   task automatic settle();
      while (pending_pixels.size() != 0 || req.valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(rwmf_pkg::csr_index_type idx, int value);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value[rwmf_pkg::CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid <= 1'b0;
      case (idx)
         rwmf_pkg::CSR_RADIUS: radius_cfg = value[1:0];
         rwmf_pkg::CSR_WIDTH: begin
            width_cfg = value[10:0];
            if (width_cfg == 0) width_cfg = 1;
            if (width_cfg > LINE) width_cfg = LINE;
         end
         rwmf_pkg::CSR_HEIGHT: begin
            height_cfg = value[12:0];
            if (height_cfg == 0) height_cfg = 1;
            if (height_cfg > 4096) height_cfg = 4096;
         end
         default: ;
      endcase
      restart_frame();
   endtask

   task automatic configure(int rad, int wid, int hgt);
      settle();
      write_reg(rwmf_pkg::CSR_RADIUS, rad);
      write_reg(rwmf_pkg::CSR_WIDTH, wid);
      write_reg(rwmf_pkg::CSR_HEIGHT, hgt);
   endtask

   // A full frame with random content, stray drain transactions before the end
   // of input, and a mix of drains and discarded pixels afterwards.
   task automatic random_frame();
      for (int i = 0; i < width_cfg * height_cfg; i++) begin
         if ($urandom_range(99) < 8) send(rwmf_pkg::KIND_DRAIN, $urandom);
         send(rwmf_pkg::KIND_PIXEL, $urandom);
      end
      while (!frame_closed) begin
         if ($urandom_range(99) < 20) send(rwmf_pkg::KIND_PIXEL, $urandom);
         else send(rwmf_pkg::KIND_DRAIN, $urandom);
      end
   endtask

   always @(posedge clock) begin
      req_fire = req.valid && req.ready;
      rsp_fire = rsp.valid && rsp.ready;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("rgba_window_median_filter: mismatch");
         $finish;
      end
      if (rsp_fire) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t unexpected result %h %h %h %h %b", $time, rsp.out_red,
                     rsp.out_green, rsp.out_blue, rsp.out_alpha, rsp.frame_end);
            errors++;
         end else begin
            pixel_out_type e;
            e = expected_pixels.pop_front();
            if (e.red !== rsp.out_red || e.green !== rsp.out_green ||
                e.blue !== rsp.out_blue || e.alpha !== rsp.out_alpha ||
                e.frame_end !== rsp.frame_end) begin
               $display("%0t expected %h %h %h %h %b actual %h %h %h %h %b", $time,
                        e.red, e.green, e.blue, e.alpha, e.frame_end, rsp.out_red,
                        rsp.out_green, rsp.out_blue, rsp.out_alpha, rsp.frame_end);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      bit idle;
      pixel_in_type p;
      idle = (idle_mode == 1 && $urandom_range(99) < 73) ||
             (idle_mode == 3 && $urandom_range(99) < 17);
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req_fire) begin
         if (!idle && pending_pixels.size() != 0) begin
            p = pending_pixels.pop_front();
            req.valid <= 1'b1;
            req.kind <= p.kind;
            req.in_red <= p.red;
            req.in_green <= p.green;
            req.in_blue <= p.blue;
            req.in_alpha <= p.alpha;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         hold_left <= 600;
         hold_done <= 1'b1;
      end
   end

   always @(negedge clock) begin
      bit stall;
      stall = (idle_mode == 2 && $urandom_range(99) < 73) ||
              (idle_mode == 3 && $urandom_range(99) < 17);
      rsp.ready <= (hold_left == 0) && !stall;
   end

   initial begin
      req.valid = 1'b0;
      req.kind = rwmf_pkg::KIND_PIXEL;
      req.in_red = '0;
      req.in_green = '0;
      req.in_blue = '0;
      req.in_alpha = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = rwmf_pkg::CSR_RADIUS;
      csr.data = '0;
      for (int i = 0; i < SLOTS * LINE; i++) line_mem[i] = '0;
      radius_cfg = rwmf_pkg::RESET_RADIUS;
      width_cfg = rwmf_pkg::RESET_WIDTH;
      height_cfg = rwmf_pkg::RESET_HEIGHT;
      restart_frame();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes of every channel on a 3x2 frame, a drain before the
      // end of input, a pixel after it, then single-pixel frames at radius zero and three.
      configure(1, 3, 2);
      send(rwmf_pkg::KIND_PIXEL, 32'h00000000);
      send(rwmf_pkg::KIND_PIXEL, 32'hFFFFFFFF);
      send(rwmf_pkg::KIND_DRAIN, 32'h12345678);
      send(rwmf_pkg::KIND_PIXEL, 32'hAA55AA55);
      send(rwmf_pkg::KIND_PIXEL, 32'h55AA55AA);
      send(rwmf_pkg::KIND_PIXEL, 32'hFF00FF00);
      send(rwmf_pkg::KIND_PIXEL, 32'h00FF00FF);
      send(rwmf_pkg::KIND_PIXEL, 32'hFFFFFFFF);
      while (!frame_closed) send(rwmf_pkg::KIND_DRAIN, 32'h0);
      configure(0, 1, 1);
      send(rwmf_pkg::KIND_PIXEL, 32'hC3A5817E);
      configure(3, 0, 0);
      send(rwmf_pkg::KIND_PIXEL, 32'h0F0F0F0F);
      configure(3, 2, 3);
      random_frame();

      // Long receiver hold-off while the sender keeps offering.
      configure(2, 12, 8);
      hold_req = 1'b1;
      random_frame();

      for (int f = 0; f < 16; f++) begin
         idle_mode = f % 4;
         configure($urandom_range(3), $urandom_range(1, 10), $urandom_range(1, 6));
         random_frame();
      end

      // Largest sizes: the start of a full-width row, then two tall frames, each cut short
      // by a write.
      idle_mode = 0;
      configure(0, 2047, 1);
      for (int i = 0; i < 40; i++) send(rwmf_pkg::KIND_PIXEL, $urandom);
      configure(1, 1, 8191);
      for (int i = 0; i < 20; i++) send(rwmf_pkg::KIND_PIXEL, $urandom);
      configure(2, 5, 4096);
      for (int i = 0; i < 30; i++) send(rwmf_pkg::KIND_PIXEL, $urandom);
      configure(1, 4, 3);
      random_frame();
      settle();

      if (errors == 0)
         $display("rgba_window_median_filter: match");
      else
         $display("rgba_window_median_filter: mismatch");
      $finish;
   end

endmodule
